[rtl/sha256_stream_hasher_assert.svh]
// ----------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Short forms for clocked implications that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 package
// Word type, control struct, pad byte, round constants, initial hash values and the SHA-256 bit functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic start;
    logic init;
  } sha_ctrl_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef4a9f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t h;
    unique case (idx)
      3'd0: h = 32'h6a09e667;
      3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f;
      3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      3'd7: h = 32'h5be0cd19;
      default: h = 32'h0;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

[rtl/sha256_core.sv]
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Runs one round per cycle on a shared round unit with a rolling schedule.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_core
  import sha256_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire sha_ctrl_t ctrl,
  input  wire word_t     block [16],
  output logic           busy,
  output word_t          chain [8]
);

  localparam logic [1:0] C_IDLE  = 2'd0;
  localparam logic [1:0] C_ROUND = 2'd1;
  localparam logic [1:0] C_FINAL = 2'd2;

  logic [1:0] state;
  logic [5:0] rnd;
  word_t      sched [16];
  word_t      a, b, c, d, e, f, g, h;
  word_t      t1, t2, w_new;

  assign busy = (state != C_IDLE);

  always_comb begin
    t1    = h + big_sigma1(e) + ((e & f) ^ (~e & g)) + round_k(rnd) + sched[0];
    t2    = big_sigma0(a) + ((a & b) ^ (a & c) ^ (b & c));
    w_new = sched[0] + small_sigma0(sched[1]) + sched[9] + small_sigma1(sched[14]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      rnd   <= 6'd0;
    end else begin
      unique case (state)
        C_IDLE: begin
          rnd <= 6'd0;
          if (ctrl.start) state <= C_ROUND;
        end
        C_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= C_FINAL;
        end
        C_FINAL: state <= C_IDLE;
        default: state <= C_IDLE;
      endcase
    end
  end

  // Working variables and the sixteen-word schedule window.
  always_ff @(posedge clk) begin
    if (state == C_IDLE && ctrl.start) begin
      for (int i = 0; i < 16; i++) sched[i] <= block[i];
      a <= chain[0]; b <= chain[1]; c <= chain[2]; d <= chain[3];
      e <= chain[4]; f <= chain[5]; g <= chain[6]; h <= chain[7];
    end else if (state == C_ROUND) begin
      for (int i = 0; i < 15; i++) sched[i] <= sched[i + 1];
      sched[15] <= w_new;
      h <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.init) begin
      for (int i = 0; i < 8; i++) chain[i] <= init_hash(3'(i));
    end else if (state == C_FINAL) begin
      chain[0] <= chain[0] + a; chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c; chain[3] <= chain[3] + d;
      chain[4] <= chain[4] + e; chain[5] <= chain[5] + f;
      chain[6] <= chain[6] + g; chain[7] <= chain[7] + h;
    end
  end

endmodule

`default_nettype wire

[rtl/sha256_stream_hasher.sv]
// A byte that does not fill the block is taken while idle; a byte that
// fills it adds one compression (start, 64 rounds, add) before the next byte.
// A last item pads one byte per cycle up to byte 56 (pausing while a full
// block compresses), runs one or two compressions, then gives eight digest
// words, one per cycle as taken. No byte is taken while a block compresses.
// Reset (synchronous, active high) loads the initial hash and clears counts.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte stream in, packing and padding sequencer, digest words out.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] has_byte
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] digest_word
  output logic             m_tlast
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PAD    = 3'd1;
  localparam logic [2:0] S_CSTART = 3'd2;
  localparam logic [2:0] S_CWAIT  = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0]  state;
  logic [2:0]  ret_state;
  logic [5:0]  fill;
  logic [63:0] bit_length;
  logic        pad_done;
  logic [2:0]  out_idx;
  word_t       block [16];
  word_t       chain [8];
  logic        core_busy;
  sha_ctrl_t   ctrl;

  logic        put_en;
  logic [7:0]  put_val;
  logic        len_en;
  logic        block_full;
  logic [4:0]  put_shift;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = chain[out_idx];
  assign m_tlast  = (out_idx == 3'd7);

  always_comb begin
    len_en     = (state == S_PAD) && pad_done && (fill == 6'd56);
    put_en     = (s_tready && s_tvalid && s_tuser) || ((state == S_PAD) && !len_en);
    put_val    = (state == S_PAD) ? (pad_done ? 8'h00 : PAD_BYTE) : s_tdata;
    block_full = (fill == 6'd63);
    put_shift  = {~fill[1:0], 3'b000};
    ctrl.start = (state == S_CSTART);
    ctrl.init  = m_tvalid && m_tready && m_tlast;
  end

  // The first byte of a word clears the rest of it; later bytes are ORed in.
  always_ff @(posedge clk) begin
    if (put_en) begin
      if (fill[1:0] == 2'd0) block[fill[5:2]] <= {put_val, 24'h0};
      else block[fill[5:2]] <= block[fill[5:2]] | ({24'h0, put_val} << put_shift);
    end else if (len_en) begin
      block[14] <= bit_length[63:32];
      block[15] <= bit_length[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret_state  <= S_IDLE;
      fill       <= 6'd0;
      bit_length <= 64'd0;
      pad_done   <= 1'b0;
      out_idx    <= 3'd0;
    end else begin
      if (put_en) fill <= fill + 6'd1;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser) bit_length <= bit_length + 64'd8;
            if (put_en && block_full) begin
              state     <= S_CSTART;
              ret_state <= s_tlast ? S_PAD : S_IDLE;
            end else if (s_tlast) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          pad_done <= 1'b1;
          if (len_en) begin
            state     <= S_CSTART;
            ret_state <= S_OUT;
          end else if (block_full) begin
            state     <= S_CSTART;
            ret_state <= S_PAD;
          end
        end
        S_CSTART: state <= S_CWAIT;
        S_CWAIT: begin
          if (!core_busy) state <= ret_state;
        end
        S_OUT: begin
          if (m_tready) begin
            out_idx <= out_idx + 3'd1;
            if (m_tlast) begin
              state      <= S_IDLE;
              fill       <= 6'd0;
              bit_length <= 64'd0;
              pad_done   <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  sha256_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .block (block),
    .busy  (core_busy),
    .chain (chain)
  );

endmodule

`default_nettype wire

[rtl/sha256_checker.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream hasher port checker
// Watches the stream ports for sequencing and output stability.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha256_stream_hasher_assert.svh"

module sha256_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tlast,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tlast
);

  // The block never takes a byte while it is giving out a digest.
  `SHA_ASSERT_NOW(a_no_overlap, m_tvalid, !s_tready, "input ready during digest output")
  // Closing a message starts padding or a compression, so no request is taken next cycle.
  `SHA_ASSERT_NEXT(a_last_busy, s_tvalid && s_tready && s_tlast, !s_tready && !m_tvalid,
                   "block not busy after last request")
  // After the final digest word the block is ready for a new message.
  `SHA_ASSERT_NEXT(a_done_ready, m_tvalid && m_tready && m_tlast, s_tready && !m_tvalid,
                   "block not idle after final digest word")
  `SHA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
                   "stalled digest word changed")

endmodule

bind sha256_stream_hasher sha256_checker u_checker (.*);

`default_nettype wire

[sim/sha256_stream_hasher_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds byte streams through the slave port with random bursts and gaps and
// stalls the digest port on changing patterns. A SHA-256 model inside the
// bench predicts every digest word, and each word taken is compared with it.
// ----------------------------------------------------------------------------

module sha256_stream_hasher_tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int RANDOM_ITEMS   = 250;
  localparam int MIN_MESSAGES   = 8;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef4a9f7, 32'hc67178f2
  };

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef struct {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
    bit         hold;      // wait for all digests to drain before sending
  } byte_req_t;

  typedef struct {
    logic [31:0] word;
    logic        word_last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic        s_tuser = 1'b0;    // [0] has_byte
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // [31:0] digest_word
  logic        m_tlast;

  byte_req_t    pending_reqs[$];
  digest_word_t digest_expect[$];

  logic [31:0] hash_state [8];
  logic [31:0] msg_block [16];
  int          byte_fill;
  logic [63:0] msg_bit_len;

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  timed_out = 1'b0;
  bit  s_taken = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  rx_mode = 0;
  int  rx_phase = 0;
  int  random_items = 0;

  sha256_stream_hasher dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic logic [31:0] rot_r(logic [31:0] x, int n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  function automatic void hash_reset();
    hash_state = HASH_INIT;
    foreach (msg_block[i]) msg_block[i] = '0;
    byte_fill = 0;
    msg_bit_len = '0;
  endfunction

  function automatic void sha_compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] t1;
    logic [31:0] t2;
    for (int i = 0; i < 16; i++) w[i] = msg_block[i];
    for (int i = 16; i < 64; i++) begin
      x = w[i-15];
      y = w[i-2];
      w[i] = w[i-16] + (rot_r(x, 7) ^ rot_r(x, 18) ^ (x >> 3)) + w[i-7]
             + (rot_r(y, 17) ^ rot_r(y, 19) ^ (y >> 10));
    end
    v = hash_state;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rot_r(v[4], 6) ^ rot_r(v[4], 11) ^ rot_r(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
      t2 = (rot_r(v[0], 2) ^ rot_r(v[0], 13) ^ rot_r(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
  endfunction

  // Bytes go in big-endian: the first byte of a word lands in its top bits.
  function automatic void absorb_byte(logic [7:0] b);
    if (byte_fill % 4 == 0) begin
      msg_block[byte_fill / 4] = {b, 24'h0};
    end else begin
      msg_block[byte_fill / 4] |= {24'h0, b} << (24 - 8 * (byte_fill % 4));
    end
    byte_fill++;
    if (byte_fill == 64) begin
      sha_compress();
      byte_fill = 0;
    end
  endfunction

  function automatic void absorb_request(logic [7:0] b, logic has_b, logic lst);
    digest_word_t dw;
    if (has_b) begin
      absorb_byte(b);
      msg_bit_len += 64'd8;
    end
    if (lst) begin
      absorb_byte(PAD_MARK);
      while (byte_fill != 56) absorb_byte(8'h00);
      msg_block[14] = msg_bit_len[63:32];
      msg_block[15] = msg_bit_len[31:0];
      sha_compress();
      for (int i = 0; i < 8; i++) begin
        dw.word = hash_state[i];
        dw.word_last = (i == 7);
        digest_expect.push_back(dw);
      end
      hash_reset();
    end
  endfunction

  // ------------------------------------------------------------- stimulus

  task automatic queue_req(logic [7:0] b, logic has_b, logic lst, bit hold);
    byte_req_t r;
    r.data_byte = b;
    r.has_byte = has_b;
    r.last = lst;
    r.hold = hold;
    pending_reqs.push_back(r);
  endtask

  // A message of len bytes with idle requests sprinkled in; the close is
  // either on the final byte or a separate request carrying no byte.
  task automatic queue_message(int len, bit hold);
    bit close_on_byte;
    bit first;
    close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    first = hold;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        queue_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, first);
        first = 1'b0;
      end
      queue_req(8'($urandom_range(0, 255)), 1'b1,
                close_on_byte && (i == len - 1), first);
      first = 1'b0;
      random_items++;
    end
    if (!close_on_byte) begin
      queue_req(8'($urandom_range(0, 255)), 1'b0, 1'b1, first);
      random_items++;
    end
  endtask

  initial begin
    int n_msgs;
    int pick;
    int len;
    int edge_lens [8];
    edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120};

    hash_reset();

    // Directed: empty message, single-byte messages of ff and 7f, a three-byte
    // message, idle requests, and a close without a byte after some bytes.
    queue_req(8'h00, 1'b0, 1'b1, 1'b0);
    queue_req(8'hff, 1'b1, 1'b1, 1'b0);
    queue_req(8'ha5, 1'b0, 1'b0, 1'b0);
    queue_req(8'h61, 1'b1, 1'b0, 1'b0);
    queue_req(8'h62, 1'b1, 1'b0, 1'b0);
    queue_req(8'h63, 1'b1, 1'b1, 1'b0);
    queue_req(8'h00, 1'b1, 1'b0, 1'b0);
    queue_req(8'h5a, 1'b0, 1'b0, 1'b0);
    queue_req(8'h80, 1'b1, 1'b0, 1'b0);
    queue_req(8'hff, 1'b0, 1'b1, 1'b0);
    queue_req(8'h7f, 1'b1, 1'b1, 1'b0);

    n_msgs = 0;
    while (random_items < RANDOM_ITEMS || n_msgs < MIN_MESSAGES) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) len = $urandom_range(0, 8);
      else if (pick < 75) len = edge_lens[$urandom_range(0, 7)];
      else len = $urandom_range(9, 40);
      queue_message(len, (n_msgs == 0) || ($urandom_range(0, 99) < 15));
      n_msgs++;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!timed_out && (pending_reqs.size() != 0 || s_tvalid
                          || digest_expect.size() != 0))
      @(posedge clk);
    if (timed_out) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (mismatches == 0 && digest_expect.size() == 0 && !timed_out)
        $display("RESULT: OK");
      else
        $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------- driver

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0
                   && !(pending_reqs[0].hold && digest_expect.size() != 0)) begin
        s_tdata  <= pending_reqs[0].data_byte;
        s_tuser  <= pending_reqs[0].has_byte;
        s_tlast  <= pending_reqs[0].last;
        s_tvalid <= 1'b1;
        void'(pending_reqs.pop_front());
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Digest port back-pressure: the pattern is re-picked at random from four modes.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_phase++;
      if (rx_phase % 48 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= (rx_phase % 4 == 0);
        default: m_tready <= (rx_phase % 16 < 8);
      endcase
    end
  end

  // -------------------------------------------------------------- monitor

  always @(posedge clk) begin
    digest_word_t want;
    if (rst) begin
      s_taken <= 1'b0;
    end else begin
      s_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) absorb_request(s_tdata, s_tuser, s_tlast);
      if (m_tvalid && m_tready) begin
        if (digest_expect.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected digest word %h last %b", $time, m_tdata, m_tlast);
        end else begin
          want = digest_expect.pop_front();
          if (m_tdata !== want.word || m_tlast !== want.word_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: digest mismatch: expected %h last %b, got %h last %b",
                       $time, want.word, want.word_last, m_tdata, m_tlast);
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles + 1 >= WATCHDOG_LIMIT) timed_out <= 1'b1;
      end
    end
  end

endmodule
